// ===== rtl/tdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdc_pkg
// Types and constants for the time-of-day clock with alarm.
// ----------------------------------------------------------------------------
package tdc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_SET_TIME  = 2'd1,
        CMD_SET_ALARM = 2'd2,
        CMD_OTHER     = 2'd3
    } cmd_t;

    localparam logic [15:0] CHAR_ZERO      = 16'd48;
    localparam logic [15:0] HOURS_PER_DAY  = 16'd24;
    localparam logic [15:0] UNITS_PER_NEXT = 16'd60;

    localparam logic [7:0] DASH_CODE = 8'h0A;

    localparam logic [7:0] POS_SEC_ONES  = 8'h01;
    localparam logic [7:0] POS_SEC_TENS  = 8'h02;
    localparam logic [7:0] POS_MIN_ONES  = 8'h04;
    localparam logic [7:0] POS_MIN_TENS  = 8'h05;
    localparam logic [7:0] POS_HOUR_ONES = 8'h07;
    localparam logic [7:0] POS_HOUR_TENS = 8'h08;

    localparam logic [2:0] LAST_IDX_VALID = 3'd5;
    localparam logic [2:0] LAST_IDX_DASH  = 3'd7;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } bcd_pair_t;

    // (tens - '0') * 10 + (ones - '0'), modulo 2^16
    function automatic logic [15:0] pair_value(input logic [7:0] tens_char,
                                               input logic [7:0] ones_char);
        logic [15:0] tv;
        logic [15:0] ov;
        tv = {8'h00, tens_char} - CHAR_ZERO;
        ov = {8'h00, ones_char} - CHAR_ZERO;
        return (tv << 3) + (tv << 1) + ov;
    endfunction

    // valid for values below 60
    function automatic bcd_pair_t split_bcd(input logic [5:0] v);
        bcd_pair_t r;
        logic [5:0] tens_x10;
        if (v >= 6'd50) begin
            r.tens = 4'd5;
        end else if (v >= 6'd40) begin
            r.tens = 4'd4;
        end else if (v >= 6'd30) begin
            r.tens = 4'd3;
        end else if (v >= 6'd20) begin
            r.tens = 4'd2;
        end else if (v >= 6'd10) begin
            r.tens = 4'd1;
        end else begin
            r.tens = 4'd0;
        end
        tens_x10 = ({2'b00, r.tens} << 3) + ({2'b00, r.tens} << 1);
        r.ones = 4'(v - tens_x10);
        return r;
    endfunction

endpackage : tdc_pkg
`default_nettype wire

// ===== rtl/time_of_day_clock_with_alarm_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_of_day_clock_with_alarm_unit
// 24-hour clock and alarm time with tick, set and display word generation.
// ----------------------------------------------------------------------------
// Each request updates the clock state in the cycle it is accepted; the
// request then waits in the check stage until the output word register is
// free, when the range check, alarm compare and BCD split are captured into
// the output word register, which then issues six display words (eight dash
// words when any field is out of range), one per cycle while m_ready is high.
// A following request is taken while the words of the previous one are still
// going out and waits in the check stage, so the sustained rate is set by the
// one-word-per-cycle output port.
// ----------------------------------------------------------------------------
module time_of_day_clock_with_alarm_unit
    import tdc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_hour_tens_char,
    input  wire logic [7:0]  s_hour_ones_char,
    input  wire logic [7:0]  s_minute_tens_char,
    input  wire logic [7:0]  s_minute_ones_char,
    input  wire logic [7:0]  s_second_tens_char,
    input  wire logic [7:0]  s_second_ones_char,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_display_word,
    output logic             m_last_word,
    output logic             m_alarm_due,
    output logic             m_time_invalid
);

    // clock state
    logic [15:0] cur_hour_reg,     cur_hour_next;
    logic [15:0] cur_minute_reg,   cur_minute_next;
    logic [15:0] cur_second_reg,   cur_second_next;
    logic [15:0] alarm_hour_reg,   alarm_hour_next;
    logic [15:0] alarm_minute_reg, alarm_minute_next;
    logic [15:0] alarm_second_reg, alarm_second_next;
    logic        alarm_armed_reg,  alarm_armed_next;

    // check stage
    logic        eval_valid_reg;
    logic        eval_move;
    logic        eval_bad;
    logic        eval_due;

    // output word register
    logic        ser_valid_reg;
    logic [2:0]  ser_idx_reg;
    logic        ser_bad_reg;
    logic        ser_due_reg;
    bcd_pair_t   ser_sec_reg;
    bcd_pair_t   ser_min_reg;
    bcd_pair_t   ser_hour_reg;
    logic        ser_done;

    logic        in_fire;
    logic        out_fire;
    logic [15:0] set_hour;
    logic [15:0] set_minute;
    logic [15:0] set_second;
    logic [15:0] sec_inc;
    logic [15:0] min_inc;
    logic [15:0] hour_inc;
    cmd_t        cmd;

    assign cmd        = cmd_t'(s_mode);
    assign in_fire    = s_valid && s_ready;
    assign out_fire   = m_valid && m_ready;
    assign set_hour   = pair_value(s_hour_tens_char, s_hour_ones_char);
    assign set_minute = pair_value(s_minute_tens_char, s_minute_ones_char);
    assign set_second = pair_value(s_second_tens_char, s_second_ones_char);
    assign sec_inc    = cur_second_reg + 16'd1;
    assign min_inc    = cur_minute_reg + 16'd1;
    assign hour_inc   = cur_hour_reg + 16'd1;

    assign ser_done  = out_fire && m_last_word;
    assign eval_move = eval_valid_reg && (!ser_valid_reg || ser_done);
    assign s_ready   = !eval_valid_reg || eval_move;

    always_comb begin
        cur_hour_next     = cur_hour_reg;
        cur_minute_next   = cur_minute_reg;
        cur_second_next   = cur_second_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        alarm_second_next = alarm_second_reg;
        alarm_armed_next  = alarm_armed_reg;
        unique case (cmd)
            CMD_TICK: begin
                cur_second_next = sec_inc;
                if (sec_inc >= UNITS_PER_NEXT) begin
                    cur_second_next = '0;
                    cur_minute_next = min_inc;
                    if (min_inc >= UNITS_PER_NEXT) begin
                        cur_minute_next = '0;
                        cur_hour_next   = (hour_inc >= HOURS_PER_DAY) ? '0 : hour_inc;
                    end
                end
            end
            CMD_SET_TIME: begin
                cur_hour_next    = set_hour;
                cur_minute_next  = set_minute;
                cur_second_next  = set_second;
                alarm_armed_next = 1'b0;
            end
            CMD_SET_ALARM: begin
                alarm_hour_next   = set_hour;
                alarm_minute_next = set_minute;
                alarm_second_next = set_second;
                alarm_armed_next  = 1'b1;
            end
            CMD_OTHER: begin
                alarm_armed_next = 1'b0;
            end
            default: begin
                alarm_armed_next = alarm_armed_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_hour_reg     <= '0;
            cur_minute_reg   <= '0;
            cur_second_reg   <= '0;
            alarm_hour_reg   <= '0;
            alarm_minute_reg <= '0;
            alarm_second_reg <= '0;
            alarm_armed_reg  <= 1'b0;
        end else if (in_fire) begin
            cur_hour_reg     <= cur_hour_next;
            cur_minute_reg   <= cur_minute_next;
            cur_second_reg   <= cur_second_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
            alarm_second_reg <= alarm_second_next;
            alarm_armed_reg  <= alarm_armed_next;
        end
    end

    assign eval_bad = (cur_hour_reg >= HOURS_PER_DAY) || (cur_minute_reg >= UNITS_PER_NEXT) ||
                      (cur_second_reg >= UNITS_PER_NEXT) ||
                      (alarm_hour_reg >= HOURS_PER_DAY) ||
                      (alarm_minute_reg >= UNITS_PER_NEXT) ||
                      (alarm_second_reg >= UNITS_PER_NEXT);

    assign eval_due = alarm_armed_reg && (alarm_hour_reg != '0) &&
                      (alarm_minute_reg != '0) && (alarm_second_reg != '0) &&
                      (cur_hour_reg >= alarm_hour_reg) &&
                      (cur_minute_reg >= alarm_minute_reg) &&
                      (cur_second_reg >= alarm_second_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_valid_reg <= 1'b0;
        end else if (in_fire) begin
            eval_valid_reg <= 1'b1;
        end else if (eval_move) begin
            eval_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= '0;
        end else if (eval_move) begin
            ser_valid_reg <= 1'b1;
            ser_idx_reg   <= '0;
        end else if (ser_done) begin
            ser_valid_reg <= 1'b0;
        end else if (out_fire) begin
            ser_idx_reg <= ser_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_move) begin
            ser_bad_reg  <= eval_bad;
            ser_due_reg  <= eval_due;
            ser_sec_reg  <= split_bcd(cur_second_reg[5:0]);
            ser_min_reg  <= split_bcd(cur_minute_reg[5:0]);
            ser_hour_reg <= split_bcd(cur_hour_reg[5:0]);
        end
    end

    always_comb begin
        m_display_word = {POS_SEC_ONES, 4'h0, ser_sec_reg.ones};
        if (ser_bad_reg) begin
            m_display_word = {8'(ser_idx_reg) + 8'd1, DASH_CODE};
        end else begin
            case (ser_idx_reg)
                3'd0:    m_display_word = {POS_SEC_ONES,  4'h0, ser_sec_reg.ones};
                3'd1:    m_display_word = {POS_SEC_TENS,  4'h0, ser_sec_reg.tens};
                3'd2:    m_display_word = {POS_MIN_ONES,  4'h0, ser_min_reg.ones};
                3'd3:    m_display_word = {POS_MIN_TENS,  4'h0, ser_min_reg.tens};
                3'd4:    m_display_word = {POS_HOUR_ONES, 4'h0, ser_hour_reg.ones};
                default: m_display_word = {POS_HOUR_TENS, 4'h0, ser_hour_reg.tens};
            endcase
        end
    end

    assign m_valid        = ser_valid_reg;
    assign m_last_word    = ser_bad_reg ? (ser_idx_reg == LAST_IDX_DASH)
                                        : (ser_idx_reg == LAST_IDX_VALID);
    assign m_alarm_due    = ser_due_reg;
    assign m_time_invalid = ser_bad_reg;

    // word index stays within the six display words
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg && !ser_bad_reg |-> ser_idx_reg <= LAST_IDX_VALID)
        else $error("display word index past last digit");

    // final word taken with nothing pending empties the output register
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_done && !eval_valid_reg |=> !ser_valid_reg)
        else $error("output register not released after last word");

    // an accepted request always reaches the check stage
    a_accept_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> eval_valid_reg)
        else $error("accepted request lost before check stage");

    // seconds and alarm arm state only change on an accepted request
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |=> $stable(cur_second_reg) && $stable(alarm_armed_reg))
        else $error("clock state changed without a request");

    // new words are loaded only after the previous request finished
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_move |-> !ser_valid_reg || ser_done)
        else $error("output register overwritten mid-request");

endmodule : time_of_day_clock_with_alarm_unit
`default_nettype wire

// ===== dv/time_of_day_clock_with_alarm_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_clock_with_alarm_unit_tb
// Self-checking bench for the time-of-day clock with alarm. Tick, set-time,
// set-alarm and other requests go in; a scoreboard keeps its own copy of the
// clock and alarm, predicts the display words of each request and checks
// every word that comes out. A directed sequence covers rollover, invalid
// digits and alarm corner cases. Random phases follow with varying idle and
// stall rates, one long output hold-off and a full drain between phases.
// ----------------------------------------------------------------------------
module time_of_day_clock_with_alarm_unit_tb;
    import tdc_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 80;
    localparam int TAIL_CYCLES  = 20;

    typedef struct {
        logic [15:0] word;
        logic        last;
        logic        due;
        logic        invalid;
    } display_word_t;

    class display_scoreboard;
        logic [15:0]   cur_hour   = '0;
        logic [15:0]   cur_minute = '0;
        logic [15:0]   cur_second = '0;
        logic [15:0]   al_hour    = '0;
        logic [15:0]   al_minute  = '0;
        logic [15:0]   al_second  = '0;
        logic          armed      = 1'b0;
        display_word_t display_queue[$];
        int            errors     = 0;

        function logic [15:0] digit_pair(logic [7:0] tens, logic [7:0] ones);
            logic [15:0] t;
            logic [15:0] o;
            t = {8'h00, tens} - CHAR_ZERO;
            o = {8'h00, ones} - CHAR_ZERO;
            return t * 16'd10 + o;
        endfunction

        function void advance_second();
            cur_second = cur_second + 16'd1;
            if (cur_second >= UNITS_PER_NEXT) begin
                cur_second = '0;
                cur_minute = cur_minute + 16'd1;
                if (cur_minute >= UNITS_PER_NEXT) begin
                    cur_minute = '0;
                    cur_hour = cur_hour + 16'd1;
                    if (cur_hour >= HOURS_PER_DAY) begin
                        cur_hour = '0;
                    end
                end
            end
        endfunction

        function void note_request(cmd_t mode, logic [7:0] ht, logic [7:0] ho,
                                   logic [7:0] mt, logic [7:0] mo,
                                   logic [7:0] st, logic [7:0] so);
            logic          bad;
            logic          due;
            logic [15:0]   words[8];
            int            n;
            display_word_t w;
            case (mode)
                CMD_TICK: begin
                    advance_second();
                end
                CMD_SET_TIME: begin
                    cur_hour   = digit_pair(ht, ho);
                    cur_minute = digit_pair(mt, mo);
                    cur_second = digit_pair(st, so);
                    armed = 1'b0;
                end
                CMD_SET_ALARM: begin
                    al_hour   = digit_pair(ht, ho);
                    al_minute = digit_pair(mt, mo);
                    al_second = digit_pair(st, so);
                    armed = 1'b1;
                end
                default: begin
                    armed = 1'b0;
                end
            endcase
            bad = cur_hour >= HOURS_PER_DAY || cur_minute >= UNITS_PER_NEXT ||
                  cur_second >= UNITS_PER_NEXT || al_hour >= HOURS_PER_DAY ||
                  al_minute >= UNITS_PER_NEXT || al_second >= UNITS_PER_NEXT;
            due = armed && al_hour != 0 && al_minute != 0 && al_second != 0 &&
                  cur_hour >= al_hour && cur_minute >= al_minute &&
                  cur_second >= al_second;
            if (bad) begin
                n = 8;
                for (int k = 0; k < 8; k++) begin
                    words[k] = {8'(k + 1), DASH_CODE};
                end
            end else begin
                n = 6;
                words[0] = {POS_SEC_ONES,  8'(cur_second % 16'd10)};
                words[1] = {POS_SEC_TENS,  8'(cur_second / 16'd10)};
                words[2] = {POS_MIN_ONES,  8'(cur_minute % 16'd10)};
                words[3] = {POS_MIN_TENS,  8'(cur_minute / 16'd10)};
                words[4] = {POS_HOUR_ONES, 8'(cur_hour % 16'd10)};
                words[5] = {POS_HOUR_TENS, 8'(cur_hour / 16'd10)};
            end
            for (int k = 0; k < n; k++) begin
                w.word    = words[k];
                w.last    = (k == n - 1);
                w.due     = due;
                w.invalid = bad;
                display_queue.push_back(w);
            end
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(logic [15:0] word, logic last, logic due, logic invalid);
            display_word_t w;
            if (display_queue.size() == 0) begin
                report($sformatf("word %h with no request pending", word));
                return;
            end
            w = display_queue.pop_front();
            if (word !== w.word)
                report($sformatf("display_word %h, want %h", word, w.word));
            if (last !== w.last)
                report($sformatf("last_word %b, want %b (word %h)", last, w.last, w.word));
            if (due !== w.due)
                report($sformatf("alarm_due %b, want %b (word %h)", due, w.due, w.word));
            if (invalid !== w.invalid)
                report($sformatf("time_invalid %b, want %b (word %h)",
                                 invalid, w.invalid, w.word));
        endtask

        function int pending();
            return display_queue.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = CMD_TICK;
    logic [7:0]  s_hour_tens_char = '0;
    logic [7:0]  s_hour_ones_char = '0;
    logic [7:0]  s_minute_tens_char = '0;
    logic [7:0]  s_minute_ones_char = '0;
    logic [7:0]  s_second_tens_char = '0;
    logic [7:0]  s_second_ones_char = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_display_word;
    logic        m_last_word;
    logic        m_alarm_due;
    logic        m_time_invalid;

    display_scoreboard sb = new;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int items_sent     = 0;

    always #5 aclk = ~aclk;

    time_of_day_clock_with_alarm_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_mode             (s_mode),
        .s_hour_tens_char   (s_hour_tens_char),
        .s_hour_ones_char   (s_hour_ones_char),
        .s_minute_tens_char (s_minute_tens_char),
        .s_minute_ones_char (s_minute_ones_char),
        .s_second_tens_char (s_second_tens_char),
        .s_second_ones_char (s_second_ones_char),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_display_word     (m_display_word),
        .m_last_word        (m_last_word),
        .m_alarm_due        (m_alarm_due),
        .m_time_invalid     (m_time_invalid)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sb.check_word(m_display_word, m_last_word, m_alarm_due, m_time_invalid);
            end
            if (s_valid && s_ready) begin
                sb.note_request(cmd_t'(s_mode), s_hour_tens_char, s_hour_ones_char,
                                s_minute_tens_char, s_minute_ones_char,
                                s_second_tens_char, s_second_ones_char);
            end
        end
    end

    // output side: random stalls, plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_served != hold_requests) begin
                hold_left = HOLD_CYCLES;
                hold_served++;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL time_of_day_clock_with_alarm_unit");
        $finish;
    end

    function automatic logic [7:0] any_char();
        return 8'($urandom);
    endfunction

    task automatic send_request(cmd_t mode, logic [7:0] ht, logic [7:0] ho,
                                logic [7:0] mt, logic [7:0] mo,
                                logic [7:0] st, logic [7:0] so);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_mode             <= mode;
        s_hour_tens_char   <= ht;
        s_hour_ones_char   <= ho;
        s_minute_tens_char <= mt;
        s_minute_ones_char <= mo;
        s_second_tens_char <= st;
        s_second_ones_char <= so;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_clock(cmd_t mode, int h, int m, int s);
        send_request(mode, 8'(CHAR_ZERO + h / 10), 8'(CHAR_ZERO + h % 10),
                     8'(CHAR_ZERO + m / 10), 8'(CHAR_ZERO + m % 10),
                     8'(CHAR_ZERO + s / 10), 8'(CHAR_ZERO + s % 10));
    endtask

    task automatic send_tick();
        send_request(CMD_TICK, any_char(), any_char(), any_char(),
                     any_char(), any_char(), any_char());
    endtask

    // drop valid and wait until every display word has gone out
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic random_phase(int stop_at);
        int         kind;
        int         h, m, s;
        int         al_h, al_m, al_s;
        logic [7:0] c[6];
        while (items_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                // set time, arm an alarm (usually at or just after it), then let it run
                if ($urandom_range(3) == 0) begin
                    h = 23;
                    m = 59;
                    s = $urandom_range(40, 59);
                end else begin
                    h = $urandom_range(23);
                    m = $urandom_range(59);
                    s = $urandom_range(59);
                end
                send_clock(CMD_SET_TIME, h, m, s);
                if ($urandom_range(99) < 70) begin
                    al_h = (h == 0) ? 1 : h;
                    al_m = (m == 0) ? 1 : m;
                    al_s = s + $urandom_range(15);
                    if (al_s > 59) al_s = 59;
                    if (al_s == 0) al_s = 1;
                end else begin
                    al_h = $urandom_range(23);
                    al_m = $urandom_range(59);
                    al_s = $urandom_range(59);
                end
                send_clock(CMD_SET_ALARM, al_h, al_m, al_s);
                repeat ($urandom_range(1, 25)) send_tick();
                if ($urandom_range(99) < 20) begin
                    send_request(CMD_OTHER, any_char(), any_char(), any_char(),
                                 any_char(), any_char(), any_char());
                end
            end else if (kind < 75) begin
                repeat ($urandom_range(1, 12)) send_tick();
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 3)) begin
                    send_request(cmd_t'($urandom_range(3)), any_char(), any_char(),
                                 any_char(), any_char(), any_char(), any_char());
                end
            end else begin
                // corrupted set, a few ticks, then a clean alarm
                for (int k = 0; k < 6; k++) begin
                    c[k] = 8'(CHAR_ZERO + $urandom_range(9));
                end
                c[$urandom_range(5)] = any_char();
                send_request($urandom_range(1) ? CMD_SET_ALARM : CMD_SET_TIME,
                             c[0], c[1], c[2], c[3], c[4], c[5]);
                repeat ($urandom_range(0, 3)) send_tick();
                send_clock(CMD_SET_ALARM, $urandom_range(23), $urandom_range(59),
                           $urandom_range(59));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_tick();
        send_clock(CMD_SET_TIME, 23, 59, 59);
        send_tick();
        send_clock(CMD_SET_TIME, 12, 34, 56);
        send_clock(CMD_SET_ALARM, 12, 34, 58);
        send_tick();
        send_tick();
        send_tick();
        send_request(CMD_OTHER, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        // hours and minutes ahead but seconds behind after the tick
        send_clock(CMD_SET_ALARM, 10, 30, 30);
        send_tick();
        send_clock(CMD_SET_ALARM, 0, 0, 0);
        send_clock(CMD_SET_ALARM, 30, 0, 1);
        send_tick();
        send_clock(CMD_SET_ALARM, 1, 1, 1);
        send_clock(CMD_SET_TIME, 24, 59, 59);
        send_tick();
        send_clock(CMD_SET_TIME, 99, 99, 99);
        send_tick();
        send_request(CMD_SET_TIME, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_tick();
        send_request(CMD_SET_TIME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // seconds field lands on 0xFFFF, wraps to zero on the tick
        send_request(CMD_SET_TIME, "0", "0", "0", "0", "/", "9");
        send_tick();
        send_request(CMD_OTHER, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A);
        drain();

        // full rate, with one long output hold-off up front
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        random_phase(items_sent + PHASE_ITEMS);
        drain();

        send_idle_pct = 54;
        recv_stall_pct <= 0;
        random_phase(items_sent + PHASE_ITEMS);
        drain();

        send_idle_pct = 0;
        recv_stall_pct <= 54;
        random_phase(items_sent + PHASE_ITEMS);
        drain();

        send_idle_pct = 6;
        recv_stall_pct <= 6;
        random_phase(items_sent + PHASE_ITEMS);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS time_of_day_clock_with_alarm_unit");
        end else begin
            $display("FAIL time_of_day_clock_with_alarm_unit");
        end
        $finish;
    end

endmodule
